/* hdl/vaf_pkg.sv */
package vaf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SQRT_STEPS    = 32;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_SUB   = 3'd1;
    localparam logic [2:0] CMD_DOT   = 3'd2;
    localparam logic [2:0] CMD_CROSS = 3'd3;
    localparam logic [2:0] CMD_LEN   = 3'd4;
    localparam logic [2:0] CMD_NORM  = 3'd5;
    localparam logic [2:0] CMD_LERP  = 3'd6;

    typedef logic [2:0] t_cmd;

    // side data that rides along the root and divide pipelines
    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] aw;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] sc;
        logic               sat;
        logic               zl;
    } t_carry;

    // returns {clip, value}
    function automatic logic [32:0] sat32(input logic signed [69:0] v);
        logic [32:0] r;
        if (v > 70'sd2147483647) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (v < -70'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

/* hdl/vaf_sqrt.sv */
module vaf_sqrt
    import vaf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_sum,
    input  t_carry      i_carry,
    output logic        o_valid,
    output logic [32:0] o_len,
    output t_carry      o_carry
);

    localparam int LAST = SQRT_STEPS - 1;

    logic [63:0] r_n   [SQRT_STEPS];
    logic [63:0] r_res [SQRT_STEPS];
    logic        r_vld [SQRT_STEPS];
    t_carry      r_car [SQRT_STEPS];

    logic [32:0] r_len;
    logic        r_fvld;
    t_carry      r_fcar;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] n_in;
        logic [63:0] res_in;
        logic        vld_in;
        t_carry      car_in;
        logic [63:0] trial;
        logic        ge;
        logic [63:0] n_n;
        logic [63:0] n_res;

        if (k == 0) begin : g_first
            assign n_in   = i_sum;
            assign res_in = 64'd0;
            assign vld_in = i_valid;
            assign car_in = i_carry;
        end else begin : g_next
            assign n_in   = r_n[k-1];
            assign res_in = r_res[k-1];
            assign vld_in = r_vld[k-1];
            assign car_in = r_car[k-1];
        end

        assign trial = res_in + BIT;
        assign ge    = n_in >= trial;
        assign n_n   = ge ? n_in - trial : n_in;
        assign n_res = ge ? (res_in >> 1) + BIT : res_in >> 1;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]   <= n_n;
                r_res[k] <= n_res;
                r_car[k] <= car_in;
            end
        end
    end

    // round to nearest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= 1'b0;
        end else if (i_en) begin
            r_fvld <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len  <= r_res[LAST][32:0] + {32'd0, (r_n[LAST] > r_res[LAST])};
            r_fcar <= r_car[LAST];
        end
    end

    assign o_valid = r_fvld;
    assign o_len   = r_len;
    assign o_carry = r_fcar;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] |-> r_n[LAST] <= (r_res[LAST] << 1))
        else $error("root remainder above bound");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_len <= 33'h1_0000_0000)
        else $error("root out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(o_len) && $stable(o_valid))
        else $error("root stage moved while stalled");

endmodule

/* hdl/vaf_div.sv */
module vaf_div
    import vaf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [32:0]               i_len,
    input  logic [2:0][31:0]          i_mag,
    input  t_carry                    i_carry,
    output logic                      o_valid,
    output logic [2:0][FRAC_BITS:0]   o_quo,
    output t_carry                    o_carry
);

    localparam int NSTEP = FRAC_BITS + 1;
    localparam int RW    = FRAC_BITS + 34;

    logic                    r_vld [NSTEP];
    t_carry                  r_car [NSTEP];
    logic [32:0]             r_len [NSTEP];
    logic [2:0][RW-1:0]      r_rem [NSTEP];
    logic [2:0][FRAC_BITS:0] r_quo [NSTEP];

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        logic                    vld_in;
        t_carry                  car_in;
        logic [32:0]             len_in;
        logic [2:0][RW-1:0]      rem_in;
        logic [2:0][FRAC_BITS:0] quo_in;
        logic [RW-1:0]           dvs;
        logic [2:0][RW-1:0]      n_rem;
        logic [2:0][FRAC_BITS:0] n_quo;

        if (s == 0) begin : g_first
            assign vld_in = i_valid;
            assign car_in = i_carry;
            assign len_in = i_len;
            assign quo_in = '0;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign rem_in[l] = (RW'(i_mag[l]) << FRAC_BITS) + RW'(i_len >> 1);
            end
        end else begin : g_next
            assign vld_in = r_vld[s-1];
            assign car_in = r_car[s-1];
            assign len_in = r_len[s-1];
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign dvs = RW'(len_in) << (FRAC_BITS - s);

        for (genvar l = 0; l < 3; l++) begin : g_cmp
            logic ge;
            assign ge       = rem_in[l] >= dvs;
            assign n_rem[l] = ge ? rem_in[l] - dvs : rem_in[l];
            assign n_quo[l] = {quo_in[l][FRAC_BITS-1:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_car[s] <= car_in;
                r_len[s] <= len_in;
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
            end
        end
    end

    assign o_valid = r_vld[NSTEP-1];
    assign o_quo   = r_quo[NSTEP-1];
    assign o_carry = r_car[NSTEP-1];

endmodule

/* hdl/vector3_alu_fixed.sv */
// Stages (Q16.16 words at the default FRAC_BITS): 4 front stages (input, multiply,
//   sum, round), 33 root stages, FRAC_BITS + 1 divide stages, 1 output register.
// Throughput: one word per cycle while the skid register is empty; the output register
//   plus a skid register keep input open while one result waits.
// Reset: synchronous, active low; clears all valid bits, data registers keep contents.
module vector3_alu_fixed
    import vaf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, weight
    input  logic [255:0] s_axis_tdata,
    // command
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // r_x, r_y, r_z, r_w, scalar_out
    output logic [159:0] m_axis_tdata,
    // zero_length, saturated
    output logic [1:0]   m_axis_tuser
);

    localparam logic [31:0] ONE  = 32'd1 << FRAC_BITS;
    localparam logic [67:0] HALF = 68'd1 << (FRAC_BITS - 1);

    logic en;

    // stage 1: inputs, b - a, a +/- b
    logic signed [31:0] w_a [4];
    logic signed [31:0] w_b [3];
    logic signed [31:0] w_t;

    logic               r1_vld;
    t_cmd               r1_cmd;
    logic signed [31:0] r1_a  [4];
    logic signed [31:0] r1_b  [3];
    logic signed [31:0] r1_t;
    logic signed [32:0] r1_d  [3];
    logic signed [32:0] r1_as [3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_a[i] = s_axis_tdata[32*i +: 32];
        end
        for (int i = 0; i < 3; i++) begin
            w_b[i] = s_axis_tdata[128 + 32*i +: 32];
        end
        w_t = s_axis_tdata[255:224];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd <= s_axis_tuser;
            r1_t   <= w_t;
            for (int i = 0; i < 4; i++) begin
                r1_a[i] <= w_a[i];
            end
            for (int i = 0; i < 3; i++) begin
                r1_b[i]  <= w_b[i];
                r1_d[i]  <= 33'(w_b[i]) - 33'(w_a[i]);
                r1_as[i] <= (s_axis_tuser == CMD_SUB) ? 33'(w_a[i]) - 33'(w_b[i])
                                                      : 33'(w_a[i]) + 33'(w_b[i]);
            end
        end
    end

    // stage 2: products
    logic signed [32:0] m_x [6];
    logic signed [32:0] m_y [6];

    logic               r2_vld;
    t_cmd               r2_cmd;
    logic signed [31:0] r2_a  [4];
    logic signed [32:0] r2_as [3];
    logic signed [65:0] r2_p  [6];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            m_x[i] = '0;
            m_y[i] = '0;
        end
        case (r1_cmd) inside
            CMD_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    m_x[i] = 33'(r1_a[i]);
                    m_y[i] = 33'(r1_b[i]);
                end
            end
            CMD_CROSS: begin
                m_x[0] = 33'(r1_a[1]); m_y[0] = 33'(r1_b[2]);
                m_x[1] = 33'(r1_a[2]); m_y[1] = 33'(r1_b[1]);
                m_x[2] = 33'(r1_a[2]); m_y[2] = 33'(r1_b[0]);
                m_x[3] = 33'(r1_a[0]); m_y[3] = 33'(r1_b[2]);
                m_x[4] = 33'(r1_a[0]); m_y[4] = 33'(r1_b[1]);
                m_x[5] = 33'(r1_a[1]); m_y[5] = 33'(r1_b[0]);
            end
            CMD_LEN, CMD_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    m_x[i] = 33'(r1_a[i]);
                    m_y[i] = 33'(r1_a[i]);
                end
            end
            CMD_LERP: begin
                for (int i = 0; i < 3; i++) begin
                    m_x[i] = r1_d[i];
                    m_y[i] = 33'(r1_t);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_cmd <= r1_cmd;
            for (int i = 0; i < 4; i++) begin
                r2_a[i] <= r1_a[i];
            end
            for (int i = 0; i < 3; i++) begin
                r2_as[i] <= r1_as[i];
            end
            for (int i = 0; i < 6; i++) begin
                r2_p[i] <= 66'(m_x[i]) * 66'(m_y[i]);
            end
        end
    end

    // stage 3: sums plus half for rounding, sum of squares
    logic signed [67:0] e [6];
    logic signed [67:0] n3_v [3];

    logic               r3_vld;
    t_cmd               r3_cmd;
    logic signed [31:0] r3_a  [4];
    logic signed [32:0] r3_as [3];
    logic signed [67:0] r3_v  [3];
    logic [63:0]        r3_ss;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            e[i] = 68'(r2_p[i]);
        end
        case (r2_cmd) inside
            CMD_DOT: begin
                n3_v[0] = e[0] + e[1] + e[2];
                n3_v[1] = e[1];
                n3_v[2] = e[2];
            end
            CMD_CROSS: begin
                n3_v[0] = e[0] - e[1];
                n3_v[1] = e[2] - e[3];
                n3_v[2] = e[4] - e[5];
            end
            default: begin
                n3_v[0] = e[0];
                n3_v[1] = e[1];
                n3_v[2] = e[2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_cmd <= r2_cmd;
            r3_ss  <= r2_p[0][63:0] + r2_p[1][63:0] + r2_p[2][63:0];
            for (int i = 0; i < 4; i++) begin
                r3_a[i] <= r2_a[i];
            end
            for (int i = 0; i < 3; i++) begin
                r3_as[i] <= r2_as[i];
                r3_v[i]  <= n3_v[i] + $signed(HALF);
            end
        end
    end

    // stage 4: scale down, interpolation offset, saturation
    logic signed [67:0] q4   [3];
    logic [32:0]        s_q  [3];
    logic [32:0]        s_as [3];
    t_carry             n4_car;

    logic               r4_vld;
    t_carry             r4_car;
    logic [63:0]        r4_ss;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q4[i] = r3_v[i] >>> FRAC_BITS;
            if (r3_cmd == CMD_LERP) begin
                q4[i] = q4[i] + 68'(r3_a[i]);
            end
            s_q[i]  = sat32(70'(q4[i]));
            s_as[i] = sat32(70'(r3_as[i]));
        end
        n4_car     = '0;
        n4_car.cmd = r3_cmd;
        n4_car.ax  = r3_a[0];
        n4_car.ay  = r3_a[1];
        n4_car.az  = r3_a[2];
        n4_car.aw  = r3_a[3];
        case (r3_cmd) inside
            CMD_ADD, CMD_SUB: begin
                n4_car.rx  = s_as[0][31:0];
                n4_car.ry  = s_as[1][31:0];
                n4_car.rz  = s_as[2][31:0];
                n4_car.sat = s_as[0][32] | s_as[1][32] | s_as[2][32];
            end
            CMD_DOT: begin
                n4_car.sc  = s_q[0][31:0];
                n4_car.sat = s_q[0][32];
            end
            CMD_CROSS, CMD_LERP: begin
                n4_car.rx  = s_q[0][31:0];
                n4_car.ry  = s_q[1][31:0];
                n4_car.rz  = s_q[2][31:0];
                n4_car.sat = s_q[0][32] | s_q[1][32] | s_q[2][32];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_car <= n4_car;
            r4_ss  <= r3_ss;
        end
    end

    // square root
    logic        w5_vld;
    logic [32:0] w5_len;
    t_carry      w5_car;
    t_carry      w5_mod;
    logic [32:0] s_len;
    logic [2:0][31:0] w5_mag;

    vaf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_vld),
        .i_sum   (r4_ss),
        .i_carry (r4_car),
        .o_valid (w5_vld),
        .o_len   (w5_len),
        .o_carry (w5_car)
    );

    always_comb begin
        s_len  = sat32({37'd0, w5_len});
        w5_mod = w5_car;
        if (w5_car.cmd == CMD_LEN) begin
            w5_mod.sc  = s_len[31:0];
            w5_mod.sat = s_len[32];
        end
        if (w5_car.cmd == CMD_NORM) begin
            w5_mod.zl = (w5_len == 33'd0);
        end
        w5_mag[0] = w5_car.ax[31] ? ~w5_car.ax + 32'd1 : w5_car.ax;
        w5_mag[1] = w5_car.ay[31] ? ~w5_car.ay + 32'd1 : w5_car.ay;
        w5_mag[2] = w5_car.az[31] ? ~w5_car.az + 32'd1 : w5_car.az;
    end

    // normalize divide
    logic                    w6_vld;
    logic [2:0][FRAC_BITS:0] w6_quo;
    t_carry                  w6_car;

    vaf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w5_vld),
        .i_len   (w5_len),
        .i_mag   (w5_mag),
        .i_carry (w5_mod),
        .o_valid (w6_vld),
        .o_quo   (w6_quo),
        .o_carry (w6_car)
    );

    // result word
    logic signed [31:0] f_r [3];
    logic signed [31:0] f_rw;
    logic signed [31:0] f_sc;
    logic               f_zl;
    logic [31:0]        f_q [3];
    logic [161:0]       fin;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_r[i] = '0;
            f_q[i] = 32'(w6_quo[i]);
        end
        f_rw = '0;
        f_sc = '0;
        f_zl = 1'b0;
        case (w6_car.cmd) inside
            CMD_ADD, CMD_SUB, CMD_CROSS, CMD_LERP: begin
                f_r[0] = w6_car.rx;
                f_r[1] = w6_car.ry;
                f_r[2] = w6_car.rz;
                f_rw   = ONE;
            end
            CMD_DOT, CMD_LEN: begin
                f_sc = w6_car.sc;
            end
            CMD_NORM: begin
                f_rw = w6_car.aw;
                if (w6_car.zl) begin
                    f_r[0] = w6_car.ax;
                    f_r[1] = w6_car.ay;
                    f_r[2] = w6_car.az;
                    f_zl   = 1'b1;
                end else begin
                    f_r[0] = w6_car.ax[31] ? -f_q[0] : f_q[0];
                    f_r[1] = w6_car.ay[31] ? -f_q[1] : f_q[1];
                    f_r[2] = w6_car.az[31] ? -f_q[2] : f_q[2];
                end
            end
            default: begin
            end
        endcase
        fin = {w6_car.sat, f_zl, f_sc, f_rw, f_r[2], f_r[1], f_r[0]};
    end

    // output register and skid
    logic         r_out_vld;
    logic [161:0] r_out;
    logic         r_skid_vld;
    logic [161:0] r_skid;
    logic         take;
    logic         emit;

    assign en   = !r_skid_vld;
    assign take = r_out_vld && m_axis_tready;
    assign emit = en && w6_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || take) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= emit;
            end
        end else if (emit) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || take) begin
            r_out <= r_skid_vld ? r_skid : fin;
        end else if (emit) begin
            r_skid <= fin;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out[159:0];
    assign m_axis_tuser  = r_out[161:160];

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word without output word");

    a_zl_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("zero length word flagged saturated");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input closed without output stall");

    a_zl_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && f_zl |-> w6_car.cmd == CMD_NORM && fin[127:96] == w6_car.aw)
        else $error("zero length word malformed");

endmodule
